// ===== rtl/button_press_classifier_defines.svh =====
// ---------------------------------------------------------------------------
// button_press_classifier_defines.svh
// assertion macros used by the checker file bpc_checker
// ---------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

// property checked every cycle outside of reset
`define BPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked every cycle, reset included
`define BPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bpc_pkg.sv =====
// ---------------------------------------------------------------------------
// bpc_pkg
// types and constants of the button press classifier
// ---------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int BUTTON_LEVELS_W = 2;
  localparam int EVENT_KIND_W    = 2;
  localparam int HOLD_W          = 16;
  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 3;

  localparam logic [HOLD_W-1:0] HOLD_MAX           = '1;
  localparam logic [HOLD_W-1:0] LONG_PRESS_DEFAULT = 16'd40;

  // register index, taken from paddr[2]
  localparam logic REG_LONG_PRESS_TICKS = 1'b0;

  typedef enum logic [EVENT_KIND_W-1:0] {
    EV_SHORT   = 2'd0,
    EV_LONG    = 2'd1,
    EV_RELEASE = 2'd2
  } event_kind_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic        button_index;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/bpc_if.sv =====
// ---------------------------------------------------------------------------
// bpc_poll_if / bpc_result_if
// valid/ready channels for poll samples and classified events
// ---------------------------------------------------------------------------
`default_nettype none

interface bpc_poll_if import bpc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [BUTTON_LEVELS_W-1:0] button_levels;

  modport source (output valid, output button_levels, input ready);
  modport sink   (input valid, input button_levels, output ready);
endinterface

interface bpc_result_if import bpc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [EVENT_KIND_W-1:0] event_kind;
  logic                    button_index;

  modport source (output valid, output event_kind, output button_index, input ready);
  modport sink   (input valid, input event_kind, input button_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/button_press_classifier.sv =====
// ---------------------------------------------------------------------------
// button_press_classifier
// short / long press detector for a row of active-low push buttons
// ---------------------------------------------------------------------------
// One request on poll carries one sample of all button levels (bit set means
// released). The block takes one request every clock cycle unless the skid
// register is full: the sample is classified combinationally against the
// stored levels and hold count and the state is updated at the edge that
// accepts it, so the next sample may follow directly. An event (short press
// start, long press, release of a short press) is registered into the output
// register, or into one skid register behind it; poll.ready drops only
// while both hold an event, so a stalled result side does not stop sampling
// until two events are pending. long_press_ticks is written over APB at
// byte address 0; write it only while no request is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module button_press_classifier
  import bpc_pkg::*;
#(
  parameter int NUM_BUTTONS = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  bpc_poll_if.sink                   poll,
  bpc_result_if.source               result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  // configuration
  logic [HOLD_W-1:0] long_press_ticks;

  // classifier state
  logic [NUM_BUTTONS-1:0] previous_levels;
  logic [NUM_BUTTONS-1:0] previous_levels_next;
  logic [HOLD_W-1:0]      hold_ticks;
  logic [HOLD_W-1:0]      hold_ticks_next;

  // output register and skid register
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  // combinational classification
  logic [NUM_BUTTONS+BUTTON_LEVELS_W-1:0] levels_ext;
  logic [NUM_BUTTONS-1:0] cur;
  logic [NUM_BUTTONS-1:0] pressed;
  logic [NUM_BUTTONS-1:0] released_now;
  logic [NUM_BUTTONS-1:0] lowest_release;
  logic [NUM_BUTTONS-1:0] odd_mask;
  logic                   none_pressed;
  logic                   one_pressed;
  logic                   press_idx;
  logic                   release_idx;
  logic [HOLD_W-1:0]      hold_inc;
  logic                   ev_valid;
  result_t                ev;

  logic accept;
  logic pop;
  logic push;
  logic cfg_write;

  // -------------------------------------------------------------------------
  // APB register access, no wait states
  // -------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_DEFAULT;
    end else if (cfg_write && (paddr[2] == REG_LONG_PRESS_TICKS)) begin
      long_press_ticks <= pwdata[HOLD_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_LONG_PRESS_TICKS) begin
      prdata = {{(APB_DATA_W-HOLD_W){1'b0}}, long_press_ticks};
    end else begin
      prdata = '0;
    end
  end

  // -------------------------------------------------------------------------
  // classification of one sample
  // -------------------------------------------------------------------------
  // buttons beyond the input field read as pressed (level zero)
  assign levels_ext = {{NUM_BUTTONS{1'b0}}, poll.button_levels};
  assign cur        = levels_ext[NUM_BUTTONS-1:0];
  assign pressed    = ~cur;

  assign none_pressed = (pressed == '0);
  assign one_pressed  = !none_pressed && ((pressed & (pressed - 1'b1)) == '0);

  // bit 0 of a button index is set for every odd position
  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      odd_mask[b] = (b % 2) == 1;
    end
  end

  // buttons that were down last tick and are up now; the lowest one is reported
  assign released_now   = cur & ~previous_levels;
  assign lowest_release = released_now & (~released_now + 1'b1);
  assign release_idx    = |(lowest_release & odd_mask);
  assign press_idx      = |(pressed & odd_mask);

  assign hold_inc = hold_ticks + 1'b1;

  always_comb begin
    ev_valid             = 1'b0;
    ev.event_kind        = EV_SHORT;
    ev.button_index      = 1'b0;
    previous_levels_next = previous_levels;
    hold_ticks_next      = hold_ticks;

    if (none_pressed) begin
      // all idle: report a short release, then restart the hold count
      previous_levels_next = cur;
      hold_ticks_next      = '0;
      if ((released_now != '0) && (hold_ticks < long_press_ticks)) begin
        ev_valid        = 1'b1;
        ev.event_kind   = EV_RELEASE;
        ev.button_index = release_idx;
      end
    end else if (one_pressed) begin
      previous_levels_next = cur;
      if ((previous_levels & pressed) != '0) begin
        // fresh press; the hold count carries on from before
        ev_valid        = 1'b1;
        ev.event_kind   = EV_SHORT;
        ev.button_index = press_idx;
      end else if (hold_ticks != HOLD_MAX) begin
        // still held: count, saturating at the top
        hold_ticks_next = hold_inc;
        if (hold_inc == long_press_ticks) begin
          ev_valid        = 1'b1;
          ev.event_kind   = EV_LONG;
          ev.button_index = press_idx;
        end
      end
    end
    // two or more pressed: chord, state left alone
  end

  // -------------------------------------------------------------------------
  // state update on every accepted sample
  // -------------------------------------------------------------------------
  assign poll.ready = !skid_valid;
  assign accept     = poll.valid && poll.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_levels <= '1;
      hold_ticks      <= '0;
    end else if (accept) begin
      previous_levels <= previous_levels_next;
      hold_ticks      <= hold_ticks_next;
    end
  end

  // -------------------------------------------------------------------------
  // output register with one skid entry
  // -------------------------------------------------------------------------
  assign pop  = out_valid && result.ready;
  assign push = accept && ev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // no new request is taken while the skid entry is full
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (out_valid && !pop) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (out_valid && !pop) begin
      if (push) begin
        skid_data <= ev;
      end
    end else if (push) begin
      out_data <= ev;
    end
  end

  assign result.valid        = out_valid;
  assign result.event_kind   = out_data.event_kind;
  assign result.button_index = out_data.button_index;

endmodule

`default_nettype wire

// ===== rtl/bpc_checker.sv =====
// ---------------------------------------------------------------------------
// bpc_checker
// port-level checks of the button press classifier, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "button_press_classifier_defines.svh"

module bpc_checker
  import bpc_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    poll_valid,
  input wire logic                    poll_ready,
  input wire logic                    result_valid,
  input wire logic                    result_ready,
  input wire logic [EVENT_KIND_W-1:0] event_kind,
  input wire logic                    pready
);

  logic poll_take;
  logic long_kind;
  logic release_kind;
  logic short_kind;
  logic result_stall;
  logic quiet;

  assign poll_take    = poll_valid && poll_ready;
  assign short_kind   = event_kind == EV_SHORT;
  assign long_kind    = event_kind == EV_LONG;
  assign release_kind = event_kind == EV_RELEASE;
  assign result_stall = result_valid && !result_ready;
  assign quiet        = !poll_take && !result_valid;

  // result stays up until taken
  `BPC_ASSERT(a_result_held, clk, rst, result_stall |=> result_valid, "result dropped")

  // an event needs a sample behind it
  `BPC_ASSERT(a_no_spurious, clk, rst, quiet |=> !result_valid, "event from nothing")

  // only the three defined event kinds leave the block
  `BPC_ASSERT(a_kind_legal, clk, rst, result_valid |-> (short_kind || long_kind || release_kind), "bad event kind")

  // nothing pending right after reset
  `BPC_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !result_valid, "result after reset")

  // register port never waits
  `BPC_ASSERT_ALWAYS(a_pready, clk, !rst |-> pready, "pready low")

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk          (clk),
  .rst          (rst),
  .poll_valid   (poll.valid),
  .poll_ready   (poll.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .event_kind   (result.event_kind),
  .pready       (pready)
);

`default_nettype wire

// ===== tb/bpc_event_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpc_event_checker
// watches the poll, result and apb traffic of the button press classifier,
// keeps its own copy of the press state and threshold, and compares every
// event that leaves the block with the oldest predicted one
// ---------------------------------------------------------------------------
module bpc_event_checker
  import bpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  bpc_poll_if                        poll,
  bpc_result_if                      result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output int                         mismatch_count,
  output int                         events_pending
);

  localparam int REPORT_LIMIT = 50;

  logic [BUTTON_LEVELS_W-1:0] levels_seen;
  logic [HOLD_W-1:0]          hold_count;
  logic [HOLD_W-1:0]          long_threshold;
  result_t                    expected_events[$];
  int                         errors = 0;

  // classify one poll sample and advance the press state
  function automatic logic classify_sample(input  logic [BUTTON_LEVELS_W-1:0] cur,
                                           output result_t                    ev);
    int   n_pressed;
    logic found;
    n_pressed = 0;
    found     = 1'b0;
    ev        = '0;
    for (int b = 0; b < BUTTON_LEVELS_W; b++)
      if (!cur[b]) n_pressed++;

    if (n_pressed == 0) begin
      // all released: report a short press that just ended
      for (int b = 0; b < BUTTON_LEVELS_W; b++) begin
        if (!levels_seen[b] && !found && hold_count < long_threshold) begin
          found           = 1'b1;
          ev.event_kind   = EV_RELEASE;
          ev.button_index = 1'(b);
        end
      end
      levels_seen = cur;
      hold_count  = '0;
    end else if (n_pressed == 1) begin
      for (int b = 0; b < BUTTON_LEVELS_W; b++) begin
        if (!cur[b] && levels_seen[b]) begin
          levels_seen[b] = 1'b0;
          if (!found) begin
            found           = 1'b1;
            ev.event_kind   = EV_SHORT;
            ev.button_index = 1'(b);
          end
        end else if (cur[b] && !levels_seen[b]) begin
          levels_seen[b] = 1'b1;
        end else if (!cur[b] && !levels_seen[b] && hold_count != HOLD_MAX) begin
          hold_count = hold_count + 1'b1;
          if (hold_count == long_threshold && !found) begin
            found           = 1'b1;
            ev.event_kind   = EV_LONG;
            ev.button_index = 1'(b);
          end
        end
      end
    end
    return found;
  endfunction

  always @(posedge clk) begin : watch
    result_t ev;
    result_t want;
    if (rst) begin
      levels_seen    = '1;
      hold_count     = '0;
      long_threshold = LONG_PRESS_DEFAULT;
      expected_events.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_LONG_PRESS_TICKS)
        long_threshold = pwdata[HOLD_W-1:0];
      if (poll.valid && poll.ready) begin
        if (classify_sample(poll.button_levels, ev))
          expected_events.push_back(ev);
      end
      if (result.valid && result.ready) begin
        if (expected_events.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $error("unexpected event: event_kind %0d button_index %0d",
                   result.event_kind, result.button_index);
        end else begin
          want = expected_events.pop_front();
          if (result.event_kind !== want.event_kind) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $error("event_kind: expected %0d, actual %0d",
                     want.event_kind, result.event_kind);
          end
          if (result.button_index !== want.button_index) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $error("button_index: expected %0d, actual %0d",
                     want.button_index, result.button_index);
          end
        end
      end
    end
    mismatch_count <= errors;
    events_pending <= expected_events.size();
  end

endmodule

// ===== tb/tb_button_press_classifier.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_button_press_classifier
// drives poll samples and threshold writes into the classifier, stalls the
// event side at random, and reports the verdict from the event checker
// ---------------------------------------------------------------------------
module tb_button_press_classifier;
  import bpc_pkg::*;

  // threshold register sits at byte address 0
  localparam logic [APB_ADDR_W-1:0] LONG_PRESS_ADDR = {REG_LONG_PRESS_TICKS, 2'b00};

  // sample patterns, active low
  localparam logic [BUTTON_LEVELS_W-1:0] LEVELS_IDLE = 2'b11;
  localparam logic [BUTTON_LEVELS_W-1:0] LEVELS_BOTH = 2'b00;

  localparam int  PHASE_ITEMS = 140;
  localparam int  END_WAIT    = 2000;
  localparam real RUN_LIMIT   = 50_000_000.0;  // 50 ms

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int   mismatch_count;
  int   events_pending;
  int   sent_items;
  logic calm;  // no idling on either side while set

  bpc_poll_if   poll();
  bpc_result_if result();

  button_press_classifier dut (
    .clk     (clk),
    .rst     (rst),
    .poll    (poll),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // prediction and comparison live beside the block
  bpc_event_checker event_check (
    .clk            (clk),
    .rst            (rst),
    .poll           (poll),
    .result         (result),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .events_pending (events_pending)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // event side: ready drops with a chance of about 27 in 100 unless calm
  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      result.ready <= calm || ($urandom_range(0, 99) >= 27);
    end
  end

  // sample with only button b pressed
  function automatic logic [BUTTON_LEVELS_W-1:0] press_of(input int b);
    return BUTTON_LEVELS_W'(~(2'b01 << b));
  endfunction

  // one poll request; random idle cycles ahead of it, then wait for acceptance
  task automatic send_levels(input logic [BUTTON_LEVELS_W-1:0] levels);
    while (!calm && $urandom_range(0, 99) < 27) begin
      @(negedge clk);
      poll.valid         <= 1'b0;
      poll.button_levels <= BUTTON_LEVELS_W'($urandom);
    end
    @(negedge clk);
    poll.valid         <= 1'b1;
    poll.button_levels <= levels;
    do @(posedge clk); while (!poll.ready);
    // both pressed is ignored by the block, so it does not count
    if (levels != LEVELS_BOTH) sent_items++;
  endtask

  // stop polling, let every predicted event come out, and let the last
  // samples that give no event settle as well
  task automatic drain_events();
    @(negedge clk);
    poll.valid <= 1'b0;
    while (events_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // threshold write, only with the block idle
  task automatic write_long_press(input logic [HOLD_W-1:0] ticks);
    drain_events();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LONG_PRESS_ADDR;
    pwdata  <= APB_DATA_W'(ticks);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // press sequences with random content: hold one button for a stretch near
  // the threshold, then release; mixed with noise samples, both-pressed
  // glitches and direct hand-overs to the other button
  task automatic random_phase(input logic [HOLD_W-1:0] threshold, input int n_items);
    int start;
    int span;
    int b;
    int d;
    start = sent_items;
    span  = (threshold <= 60) ? int'(threshold) + 3 : 60;
    while (sent_items - start < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_levels(BUTTON_LEVELS_W'($urandom));
      end else begin
        b = $urandom_range(0, BUTTON_LEVELS_W - 1);
        d = $urandom_range(1, span);
        repeat (d) begin
          if ($urandom_range(0, 11) == 0) send_levels(LEVELS_BOTH);
          send_levels(press_of(b));
        end
        // now and then no release, so the hold count carries into the next press
        if ($urandom_range(0, 5) != 0)
          repeat ($urandom_range(1, 3)) send_levels(LEVELS_IDLE);
      end
    end
  endtask

  initial begin
    logic [HOLD_W-1:0] phase_ticks[6];
    int                waited;

    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    poll.valid         = 1'b0;
    poll.button_levels = LEVELS_IDLE;
    calm               = 1'b0;
    sent_items         = 0;
    phase_ticks        = '{16'd40, 16'd1, 16'd2, 16'hFFFF, 16'd0, 16'd23};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed, threshold at its reset value ---
    send_levels(LEVELS_IDLE);   // idle with nothing pressed before
    send_levels(press_of(0));   // short press start
    send_levels(press_of(0));   // held one tick
    send_levels(LEVELS_IDLE);   // release of a short press
    send_levels(press_of(1));
    send_levels(LEVELS_IDLE);
    send_levels(LEVELS_BOTH);   // two pressed: ignored
    send_levels(press_of(0));
    send_levels(press_of(1));   // hand-over without idle, count carried over
    send_levels(LEVELS_BOTH);
    send_levels(LEVELS_IDLE);   // release names button 1

    // --- threshold one: long event on first hold tick ---
    write_long_press(16'd1);
    send_levels(press_of(0));
    send_levels(press_of(0));
    send_levels(press_of(0));
    send_levels(LEVELS_IDLE);   // held past threshold, no release event
    send_levels(press_of(1));
    send_levels(LEVELS_IDLE);

    // --- threshold zero: neither long nor release events ---
    write_long_press(16'd0);
    send_levels(press_of(0));
    send_levels(press_of(0));
    send_levels(LEVELS_IDLE);

    // --- random phases over several thresholds, extremes included ---
    foreach (phase_ticks[i]) begin
      write_long_press(phase_ticks[i]);
      calm = (i == 2);
      random_phase(phase_ticks[i], PHASE_ITEMS);
    end
    calm = 1'b0;

    // --- wind down and verdict ---
    @(negedge clk);
    poll.valid <= 1'b0;
    waited = 0;
    while (events_pending != 0 && waited < END_WAIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (events_pending != 0)
      $error("%0d predicted events never came out", events_pending);

    if (mismatch_count == 0 && events_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
